// File: rtl/apf_pkg.sv
package apf_pkg;

  // Fixed banned-string table. Slots past the filled ones are empty and never match.
  localparam int TABLE_SLOTS = 32;
  localparam int PAT_MAX     = 12;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DOT     = 8'h2e;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_BANNED  = 2'd1;
  localparam logic [1:0] REASON_ADDRESS = 2'd2;

  localparam logic [1:0] LEVEL_START   = 2'd0;
  localparam logic [1:0] LEVEL_FIRST   = 2'd1;
  localparam logic [1:0] LEVEL_ADDRESS = 2'd3;

  // Lengths of the strings in bytes.
  localparam logic [3:0] PAT_LEN [TABLE_SLOTS] = '{
    0: 4'd4,  1: 4'd3,  2: 4'd3,  3: 4'd3,  4: 4'd2,  5: 4'd6,
    6: 4'd4,  7: 4'd9,  8: 4'd8,  9: 4'd8,  10: 4'd4, 11: 4'd7,
    12: 4'd2, 13: 4'd8, 14: 4'd8, 15: 4'd4, 16: 4'd4,
    default: 4'd0
  };

  // String text, first character in the most significant byte.
  localparam logic [PAT_MAX*8-1:0] PAT_TEXT [TABLE_SLOTS] = '{
    0:  96'h68747470_00000000_00000000,
    1:  96'h636f6d00_00000000_00000000,
    2:  96'h6e657400_00000000_00000000,
    3:  96'h6f726700_00000000_00000000,
    4:  96'h72750000_00000000_00000000,
    5:  96'h726f6e64_6f720000_00000000,
    6:  96'h7777772e_00000000_00000000,
    7:  96'h65706963_776f726c_64000000,
    8:  96'h776f772d_6c696f6e_00000000,
    9:  96'h656c6772_61636961_00000000,
    10: 96'h75776f77_00000000_00000000,
    11: 96'h776f772d_61676500_00000000,
    12: 96'h73750000_00000000_00000000,
    13: 96'h776f772d_66697265_00000000,
    14: 96'h776f772d_7172736b_00000000,
    15: 96'h71776f77_00000000_00000000,
    16: 96'h7172736b_00000000_00000000,
    default: '0
  };

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last_byte;
  } msg_t;

  typedef struct packed {
    logic       blocked;
    logic [1:0] block_reason;
    logic [4:0] pattern_index;
  } verdict_t;

  // Window cell control: shift in the neighbor's byte, or clear at message end.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Per-slot compare of one window position. A position ahead of a string's
  // first character passes; a string that cannot fit in the window fails.
  function automatic logic [TABLE_SLOTS-1:0] pos_match(logic [7:0] b, int pos, int win);
    logic [TABLE_SLOTS-1:0] m;
    int len;
    int off;
    m = '0;
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      len = int'(PAT_LEN[s]);
      off = pos - (win - len);
      if (len == 0 || len > win || len > PAT_MAX) begin
        m[s] = 1'b0;
      end else if (off < 0) begin
        m[s] = 1'b1;
      end else begin
        m[s] = (b == PAT_TEXT[s][(PAT_MAX-1-off)*8 +: 8]);
      end
    end
    return m;
  endfunction

endpackage

// File: rtl/chat_ad_pattern_filter_core.sv
// Chat filter core. Takes a message one byte per transfer on the msg channel
// and gives one verdict transfer for every message, on the byte marked
// last_byte. Bytes are lowercased (ASCII A-Z only) and pass through a row of
// window cells; every banned string is checked ending at the current byte, and
// the lowest string index seen in the message is reported with reason 1. A
// dotted numeric address (a first segment and then two non-empty all-digit
// segments, each closed by a dot, followed by any further non-space byte) gives
// reason 2 when no banned string hit. A new byte is taken in every cycle while
// msg_stall is low: the window shifts once per transfer and the segment tracker
// updates combinationally. The verdict is registered in the output register, or
// in a second holding stage that lets the core keep taking bytes while a verdict
// waits, so msg_stall rises only when both stages are full.
module chat_ad_pattern_filter_core #(
  parameter int WINDOW_BYTES  = 9,
  parameter int PATTERN_COUNT = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_stall,
  input  apf_pkg::msg_t     msg,
  output logic              verdict_valid,
  input  logic              verdict_stall,
  output apf_pkg::verdict_t verdict
);

  localparam int CELLS = WINDOW_BYTES - 1;

  logic msg_fire;
  logic verdict_fire;
  logic [7:0] lc_byte;
  apf_pkg::cell_ctrl_t cell_ctrl;

  logic [7:0] cell_q [CELLS];
  logic [apf_pkg::TABLE_SLOTS-1:0] cell_hits [CELLS];
  logic [apf_pkg::TABLE_SLOTS-1:0] cur_hits;
  logic [apf_pkg::TABLE_SLOTS-1:0] match_all;

  logic hit_now;
  logic [4:0] hit_idx;

  // Per-message tracker state.
  logic       word_hit,           word_hit_next;
  logic [4:0] word_hit_index,     word_hit_index_next;
  logic [1:0] segment_level,      segment_level_next;
  logic       segment_all_digits, segment_all_digits_next;
  logic       segment_nonempty,   segment_nonempty_next;
  logic       address_hit,        address_hit_next;

  apf_pkg::verdict_t result;

  // Output register plus one holding stage.
  logic              skid_valid;
  apf_pkg::verdict_t skid;

  assign msg_stall    = skid_valid;
  assign msg_fire     = msg_valid && !msg_stall;
  assign verdict_fire = verdict_valid && !verdict_stall;

  always_comb begin
    lc_byte = msg.msg_byte;
    if (msg.msg_byte >= apf_pkg::CHAR_UPPER_A && msg.msg_byte <= apf_pkg::CHAR_UPPER_Z) begin
      lc_byte = msg.msg_byte + apf_pkg::CASE_OFFSET;
    end
  end

  assign cell_ctrl.shift = msg_fire;
  assign cell_ctrl.clear = msg_fire && msg.last_byte;

  // Window row: the newest stored byte sits in the highest cell, and each cell
  // hands its byte down to the next lower one on every transfer.
  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    logic [7:0] d_in;
    if (j == CELLS - 1) begin : g_head
      assign d_in = lc_byte;
    end else begin : g_body
      assign d_in = cell_q[j+1];
    end
    apf_cell #(
      .WINDOW_BYTES(WINDOW_BYTES),
      .POS         (j)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .ctrl(cell_ctrl),
      .d   (d_in),
      .q   (cell_q[j]),
      .hits(cell_hits[j])
    );
  end

  // The current byte is the last window position.
  assign cur_hits = apf_pkg::pos_match(lc_byte, WINDOW_BYTES - 1, WINDOW_BYTES);

  always_comb begin
    match_all = cur_hits;
    for (int j = 0; j < CELLS; j++) begin
      match_all = match_all & cell_hits[j];
    end
  end

  // The lowest matching string index wins.
  always_comb begin
    hit_now = 1'b0;
    hit_idx = '0;
    for (int i = PATTERN_COUNT - 1; i >= 0; i--) begin
      if (match_all[i]) begin
        hit_now = 1'b1;
        hit_idx = 5'(i);
      end
    end
  end

  // Tracker update for the byte on the msg channel. Spaces are invisible to the
  // segment logic; once the address level is reached any other byte flags it.
  always_comb begin
    word_hit_next           = word_hit;
    word_hit_index_next     = word_hit_index;
    segment_level_next      = segment_level;
    segment_all_digits_next = segment_all_digits;
    segment_nonempty_next   = segment_nonempty;
    address_hit_next        = address_hit;

    if (hit_now && (!word_hit || hit_idx < word_hit_index)) begin
      word_hit_next       = 1'b1;
      word_hit_index_next = hit_idx;
    end

    if (lc_byte != apf_pkg::CHAR_SPACE) begin
      if (segment_level == apf_pkg::LEVEL_ADDRESS) begin
        address_hit_next = 1'b1;
      end else if (lc_byte == apf_pkg::CHAR_DOT) begin
        if (segment_level == apf_pkg::LEVEL_START) begin
          segment_level_next = apf_pkg::LEVEL_FIRST;
        end else if (segment_nonempty && segment_all_digits) begin
          segment_level_next = segment_level + 2'd1;
        end else begin
          segment_level_next = apf_pkg::LEVEL_FIRST;
        end
        segment_all_digits_next = 1'b1;
        segment_nonempty_next   = 1'b0;
      end else begin
        segment_nonempty_next = 1'b1;
        if (lc_byte < apf_pkg::CHAR_ZERO || lc_byte > apf_pkg::CHAR_NINE) begin
          segment_all_digits_next = 1'b0;
        end
      end
    end
  end

  // Verdict from the state as it stands after the last byte.
  always_comb begin
    if (word_hit_next) begin
      result.blocked       = 1'b1;
      result.block_reason  = apf_pkg::REASON_BANNED;
      result.pattern_index = word_hit_index_next;
    end else if (address_hit_next) begin
      result.blocked       = 1'b1;
      result.block_reason  = apf_pkg::REASON_ADDRESS;
      result.pattern_index = '0;
    end else begin
      result.blocked       = 1'b0;
      result.block_reason  = apf_pkg::REASON_NONE;
      result.pattern_index = '0;
    end
  end

  // Tracker registers: cleared at reset and after each message's last byte.
  always_ff @(posedge clk) begin
    if (rst || (msg_fire && msg.last_byte)) begin
      word_hit           <= 1'b0;
      word_hit_index     <= '0;
      segment_level      <= apf_pkg::LEVEL_START;
      segment_all_digits <= 1'b1;
      segment_nonempty   <= 1'b0;
      address_hit        <= 1'b0;
    end else if (msg_fire) begin
      word_hit           <= word_hit_next;
      word_hit_index     <= word_hit_index_next;
      segment_level      <= segment_level_next;
      segment_all_digits <= segment_all_digits_next;
      segment_nonempty   <= segment_nonempty_next;
      address_hit        <= address_hit_next;
    end
  end

  // Output stages. A new verdict goes straight to the output register when it
  // is free or being taken this cycle; otherwise it waits in the holding stage,
  // which then stalls the msg channel until the output register drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (skid_valid) begin
      if (verdict_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (msg_fire && msg.last_byte) begin
      if (verdict_valid && !verdict_fire) begin
        skid_valid <= 1'b1;
      end else begin
        verdict_valid <= 1'b1;
      end
    end else if (verdict_fire) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (verdict_fire) begin
        verdict <= skid;
      end
    end else if (msg_fire && msg.last_byte) begin
      if (verdict_valid && !verdict_fire) begin
        skid <= result;
      end else begin
        verdict <= result;
      end
    end
  end

endmodule

// File: rtl/apf_cell.sv
module apf_cell #(
  parameter int WINDOW_BYTES = 9,
  parameter int POS          = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  apf_pkg::cell_ctrl_t           ctrl,
  input  logic [7:0]                    d,
  output logic [7:0]                    q,
  output logic [apf_pkg::TABLE_SLOTS-1:0] hits
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      q <= '0;
    end else if (ctrl.shift) begin
      q <= d;
    end
  end

  // Compares the held byte against every string's character for this position.
  assign hits = apf_pkg::pos_match(q, POS, WINDOW_BYTES);

endmodule

// File: bench/chat_ad_pattern_filter_core_tb.sv
`timescale 1ns / 100ps

// The test sends whole messages one byte at a time through the msg channel.
// At every byte transfer, a scoreboard model of the filter updates its own
// window and segment state. Each verdict transfer is checked field by field
// against the oldest verdict still owed.
module chat_ad_pattern_filter_core_tb;

  localparam int WIN_BYTES   = 9;
  localparam int N_PATTERNS  = 17;
  localparam int ITEM_TARGET = 1150;
  localparam int LONG_HOLD   = 150;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN       = 10;
  localparam int N_ROWS      = 7;

  // One directed message. The typed verdict is used only where known is set.
  // Otherwise the scoreboard model supplies the verdict.
  typedef struct {
    string             text;
    int                slot;
    bit                shout;
    bit                zero_end;
    bit                known;
    apf_pkg::verdict_t want;
  } case_row_t;

  // Entry per message: a typed verdict, or a request to use the model's verdict.
  typedef struct packed {
    bit                known;
    apf_pkg::verdict_t want;
  } plan_t;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              msg_valid     = 1'b0;
  logic              msg_stall;
  apf_pkg::msg_t     msg           = '0;
  logic              verdict_valid;
  logic              verdict_stall = 1'b0;
  apf_pkg::verdict_t verdict;

  // Scoreboard model state: previous bytes of the message and the two trackers.
  logic [7:0] hist [WIN_BYTES-1];
  bit         seen_banned;
  logic [4:0] banned_idx;
  logic [1:0] seg_level;
  bit         seg_digits;
  bit         seg_filled;
  bit         seen_address;

  apf_pkg::verdict_t verdict_q [$];
  plan_t             plan_q [$];
  int       msgs_done     = 0;
  int       verdicts_done = 0;
  int       bytes_sent    = 0;
  int       idle_cycles   = 0;
  int       errors        = 0;
  bit       tx_idle       = 1'b1;
  bit       rx_idle       = 1'b1;
  bit       hold_off_req  = 1'b0;

  // Directed messages. The rows cover these cases:
  //   - a lone zero byte
  //   - a banned string in lower and in mixed case
  //   - a dotted address
  //   - both hits in one message
  //   - bytes with the top bit set
  //   - an empty segment
  //   - a string that fills the whole window
  case_row_t case_rows [N_ROWS] = '{
    '{"",         -1, 1'b0, 1'b1, 1'b1, '{1'b0, apf_pkg::REASON_NONE,    5'd0}},
    '{"ru",       -1, 1'b0, 1'b0, 1'b1, '{1'b1, apf_pkg::REASON_BANNED,  5'd4}},
    '{"Su",       -1, 1'b0, 1'b0, 1'b1, '{1'b1, apf_pkg::REASON_BANNED,  5'd12}},
    '{"1.2.3.4",  -1, 1'b0, 1'b0, 1'b1, '{1'b1, apf_pkg::REASON_ADDRESS, 5'd0}},
    '{"1.2.3.ru", -1, 1'b0, 1'b0, 1'b1, '{1'b1, apf_pkg::REASON_BANNED,  5'd4}},
    '{"\377\301", -1, 1'b0, 1'b0, 1'b1, '{1'b0, apf_pkg::REASON_NONE,    5'd0}},
    '{"1..2.3.4",  7, 1'b1, 1'b0, 1'b0, '{1'b0, apf_pkg::REASON_NONE,    5'd0}}
  };

  chat_ad_pattern_filter_core #(
    .WINDOW_BYTES (WIN_BYTES),
    .PATTERN_COUNT(N_PATTERNS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .msg          (msg),
    .verdict_valid(verdict_valid),
    .verdict_stall(verdict_stall),
    .verdict      (verdict)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_scan();
    for (int k = 0; k < WIN_BYTES - 1; k++) hist[k] = 8'h00;
    seen_banned  = 1'b0;
    banned_idx   = 5'd0;
    seg_level    = apf_pkg::LEVEL_START;
    seg_digits   = 1'b1;
    seg_filled   = 1'b0;
    seen_address = 1'b0;
  endfunction

  // Advances the model by one byte. Returns 1 when the byte closes a message,
  // with the verdict in v.
  function automatic bit scan_byte(input apf_pkg::msg_t m, output apf_pkg::verdict_t v);
    logic [7:0] c;
    logic [7:0] cur [WIN_BYTES];
    int         len;
    bit         same;
    bit         found;
    v     = '0;
    found = 1'b0;
    c     = m.msg_byte;
    if (c >= apf_pkg::CHAR_UPPER_A && c <= apf_pkg::CHAR_UPPER_Z)
      c = c + apf_pkg::CASE_OFFSET;
    for (int k = 0; k < WIN_BYTES - 1; k++) cur[k] = hist[k];
    cur[WIN_BYTES-1] = c;

    // Only the first string in table order that ends at this byte counts.
    // The lowest index seen in the message is kept.
    for (int s = 0; s < N_PATTERNS && s < apf_pkg::TABLE_SLOTS && !found; s++) begin
      len = int'(apf_pkg::PAT_LEN[s]);
      if (len == 0 || len > WIN_BYTES || len > apf_pkg::PAT_MAX) continue;
      same = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (cur[WIN_BYTES-len+k] != apf_pkg::PAT_TEXT[s][(apf_pkg::PAT_MAX-1-k)*8 +: 8])
          same = 1'b0;
      end
      if (same) begin
        found = 1'b1;
        if (!seen_banned || s < banned_idx) begin
          seen_banned = 1'b1;
          banned_idx  = 5'(s);
        end
      end
    end
    for (int k = 0; k < WIN_BYTES - 1; k++) hist[k] = cur[k+1];

    // Segment tracker. Spaces are invisible to it. Once it reaches the top
    // level, any further byte marks an address.
    if (c != apf_pkg::CHAR_SPACE) begin
      if (seg_level == apf_pkg::LEVEL_ADDRESS) begin
        seen_address = 1'b1;
      end else if (c == apf_pkg::CHAR_DOT) begin
        if (seg_level == apf_pkg::LEVEL_START) seg_level = apf_pkg::LEVEL_FIRST;
        else if (seg_filled && seg_digits) seg_level = seg_level + 2'd1;
        else seg_level = apf_pkg::LEVEL_FIRST;
        seg_digits = 1'b1;
        seg_filled = 1'b0;
      end else begin
        seg_filled = 1'b1;
        if (c < apf_pkg::CHAR_ZERO || c > apf_pkg::CHAR_NINE) seg_digits = 1'b0;
      end
    end

    if (!m.last_byte) return 1'b0;
    if (seen_banned) v = '{1'b1, apf_pkg::REASON_BANNED, banned_idx};
    else if (seen_address) v = '{1'b1, apf_pkg::REASON_ADDRESS, 5'd0};
    else v = '{1'b0, apf_pkg::REASON_NONE, 5'd0};
    clear_scan();
    return 1'b1;
  endfunction

  // Appends banned string number slot. Letters are made upper case either all
  // of them or at random.
  function automatic void add_banned(ref logic [7:0] q [$], input int slot,
                                     input bit all_caps);
    logic [7:0] ch;
    for (int k = 0; k < int'(apf_pkg::PAT_LEN[slot]); k++) begin
      ch = apf_pkg::PAT_TEXT[slot][(apf_pkg::PAT_MAX-1-k)*8 +: 8];
      if (ch >= "a" && ch <= "z" && (all_caps || $urandom_range(0, 1) == 1))
        ch = ch - apf_pkg::CASE_OFFSET;
      q = {q, ch};
    end
  endfunction

  // One byte transfer. The sender may idle first. When it does not idle,
  // valid stays high across back-to-back bytes.
  task automatic send_byte(input apf_pkg::msg_t item);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= item;
    do @(posedge clk); while (msg_stall);
  endtask

  task automatic send_msg(input logic [7:0] body [$], input bit known,
                          input apf_pkg::verdict_t want);
    plan_q = {plan_q, plan_t'{known, want}};
    foreach (body[i]) begin
      send_byte('{msg_byte: body[i], last_byte: (i == body.size() - 1)});
    end
    msgs_done++;
    bytes_sent += body.size();
  endtask

  // A random message is built from pieces. Most pieces are banned strings or
  // dotted addresses, so that both trackers are exercised. Some address groups
  // are empty or broken. The rest of the pieces are noise.
  task automatic send_random_msg();
    logic [7:0] body [$];
    string      filler;
    int         ndig;
    filler = " .0123456789acegilmnoprstuwCOMNRU-";
    if ($urandom_range(0, 5) == 0) begin
      body = {body, 8'($urandom_range(0, 255))};
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: add_banned(body, $urandom_range(0, N_PATTERNS - 1), 1'b0);
          3, 4, 5: begin
            for (int g = 0; g < 4; g++) begin
              ndig = ($urandom_range(0, 8) == 0) ? 0 : $urandom_range(1, 3);
              repeat (ndig) body = {body, apf_pkg::CHAR_ZERO + 8'($urandom_range(0, 9))};
              if ($urandom_range(0, 9) == 0) body = {body, 8'("x")};
              if ($urandom_range(0, 5) == 0) body = {body, apf_pkg::CHAR_SPACE};
              if (g < 3) body = {body, apf_pkg::CHAR_DOT};
            end
          end
          6, 7: repeat ($urandom_range(1, 4)) body = {body, 8'($urandom_range(0, 255))};
          default: begin
            repeat ($urandom_range(1, 4))
              body = {body, 8'(filler[$urandom_range(0, filler.len() - 1)])};
          end
        endcase
      end
    end
    send_msg(body, 1'b0, '0);
  endtask

  // Scoreboard and watchdog. Byte transfers are handled before the verdict
  // transfer at the same edge, so a verdict in the same cycle would still
  // find its expectation.
  always @(posedge clk) begin
    apf_pkg::verdict_t due;
    apf_pkg::verdict_t want;
    plan_t             plan;
    bit                moved;
    moved = 1'b0;
    if (!rst && msg_valid && !msg_stall) begin
      moved = 1'b1;
      if (scan_byte(msg, due)) begin
        plan = plan_q.pop_front();
        want = plan.known ? plan.want : due;
        verdict_q = {verdict_q, want};
      end
    end
    if (!rst && verdict_valid && !verdict_stall) begin
      moved = 1'b1;
      verdicts_done++;
      if (verdict_q.size() == 0) begin
        $error("verdict transfer with none expected: %0h", verdict);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (verdict.blocked !== want.blocked) begin
          $error("blocked: expected %0d, got %0d", want.blocked, verdict.blocked);
          errors++;
        end
        if (verdict.block_reason !== want.block_reason) begin
          $error("block_reason: expected %0d, got %0d",
                 want.block_reason, verdict.block_reason);
          errors++;
        end
        if (verdict.pattern_index !== want.pattern_index) begin
          $error("pattern_index: expected %0d, got %0d",
                 want.pattern_index, verdict.pattern_index);
          errors++;
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("chat_ad_pattern_filter_core_tb failed");
      $finish;
    end
  end

  // Verdict receiver. Before each verdict it stalls for a random number of
  // cycles. On request it holds off for one long stretch instead.
  initial begin
    int hold;
    wait (!rst);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold         = LONG_HOLD;
      end else begin
        hold = rx_idle ? $urandom_range(0, 6) : 0;
      end
      if (hold > 0) begin
        verdict_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      verdict_stall <= 1'b0;
      do @(posedge clk); while (!verdict_valid);
    end
  end

  initial begin
    logic [7:0] body [$];
    int         msg_count;
    clear_scan();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (case_rows[r]) begin
      body.delete();
      for (int i = 0; i < case_rows[r].text.len(); i++)
        body = {body, 8'(case_rows[r].text[i])};
      if (case_rows[r].slot >= 0) add_banned(body, case_rows[r].slot, case_rows[r].shout);
      if (case_rows[r].zero_end) body = {body, 8'h00};
      send_msg(body, case_rows[r].known, case_rows[r].want);
    end

    // Let the core drain completely. Then hold off the verdict side while
    // one-byte messages keep arriving, until both verdict stages fill and the
    // core stalls its input.
    msg_valid <= 1'b0;
    wait (verdicts_done >= msgs_done);
    @(posedge clk);
    hold_off_req = 1'b1;
    tx_idle      = 1'b0;
    repeat (12) begin
      body.delete();
      body = {body, 8'($urandom_range(0, 255))};
      send_msg(body, 1'b0, '0);
    end
    msg_valid <= 1'b0;
    wait (verdicts_done >= msgs_done);
    @(posedge clk);

    // Random traffic. Every sixteen messages, each side's idling is turned on
    // or off, so that some stretches run at full rate.
    msg_count = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (msg_count % 16 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      send_random_msg();
      msg_count++;
    end
    msg_valid <= 1'b0;

    wait (verdicts_done >= msgs_done);
    repeat (DRAIN) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d verdicts expected but never transferred", verdict_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("chat_ad_pattern_filter_core_tb passed");
    end else begin
      $display("chat_ad_pattern_filter_core_tb failed");
    end
    $finish;
  end

endmodule
